// ===== src/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

  // Default sizes of the page table and the free-list set.
  localparam int unsigned PAGE_BITS_DEF   = 12;
  localparam int unsigned ORDER_LIMIT_DEF = 10;

  // Fixed field widths.
  localparam int unsigned ORD_W  = 4;
  localparam int unsigned LOW_W  = 12;
  localparam int unsigned HIGH_W = 13;
  localparam int unsigned CFG_W  = 13;

  // Reset values of the region registers.
  localparam logic [LOW_W-1:0]  LOW_RESET  = 12'd1024;
  localparam logic [HIGH_W-1:0] HIGH_RESET = 13'd3840;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_BAD_ORDER = 2'd2
  } status_e;

  typedef enum logic {
    REG_LOW  = 1'b0,
    REG_HIGH = 1'b1
  } reg_e;

  // Datapath micro-operations issued by the controller each cycle.
  typedef enum logic [5:0] {
    OP_IDLE, OP_LOAD, OP_CLR, OP_RD_A, OP_WR_LNK0, OP_RD_PG, OP_WR_MARK,
    OP_B_INIT, OP_RD_I, OP_I_INC, OP_G_INIT, OP_J_INIT, OP_RD_J, OP_J_INC,
    OP_ORD_INC, OP_T_INIT, OP_WR_TAIL, OP_I_ADV,
    OP_P_RD, OP_P_WR, OP_P_RDO, OP_P_WRO,
    OP_U_RD, OP_U_CAP, OP_U_RDP, OP_U_WRP, OP_U_RDN, OP_U_WRN, OP_U_RDX, OP_U_WRX,
    OP_A_INIT, OP_A_NEXT, OP_A_FAIL, OP_A_TAKE, OP_A_SPLIT, OP_K0, OP_RD_K,
    OP_A_WRK, OP_A_RES, OP_F_WRK, OP_BAD, OP_F_RDB, OP_F_MRG, OP_F_FIN
  } dp_op_e;

  // Datapath conditions seen by the controller.
  typedef struct packed {
    cmd_e cmd;
    logic ord_bad;
    logic pg_zero;
    logic a_last;
    logic free_ok;
    logic i_lt_hi;
    logic grow_ok;
    logic j_last;
    logic tail_more;
    logic old_nz;
    logic p_nz;
    logic n_nz;
    logic head_zero;
    logic o_max;
    logic o_gt_ord;
    logic k_more;
    logic merge_ok;
    logic bud_ok;
  } dp_status_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_MARK_WR, S_BL_RD, S_BL_WR,
    S_B_INIT, S_B_TEST, S_B_CHK, S_B_GROW, S_B_JRD, S_B_JCHK, S_B_TCHK, S_B_TWR,
    S_B_ADV, S_P_RD, S_P_WR, S_P_RDO, S_P_WRO,
    S_U_RD, S_U_CAP, S_U_CHKP, S_U_WRP, S_U_CHKN, S_U_WRN, S_U_RDX, S_U_WRX,
    S_A_FIND, S_A_SPLIT, S_A_KRD, S_A_KWR,
    S_F_KRD, S_F_KWR, S_F_MRG, S_F_BCHK, S_F_UP, S_DONE
  } ctl_state_e;

endpackage
`default_nettype wire

// ===== src/bpa_datapath.sv =====
`default_nettype none
module bpa_datapath #(
  parameter int unsigned PAGE_BITS   = bpa_pkg::PAGE_BITS_DEF,
  parameter int unsigned ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  bpa_pkg::dp_op_e              op_i,
  input  bpa_pkg::cmd_e                in_cmd_i,
  input  wire [PAGE_BITS-1:0]          in_page_i,
  input  wire [bpa_pkg::ORD_W-1:0]     in_order_i,
  input  wire                          in_usable_i,
  input  wire                          in_alloc_i,
  input  wire                          cfg_we_i,
  input  bpa_pkg::reg_e                cfg_index_i,
  input  wire [bpa_pkg::CFG_W-1:0]     cfg_data_i,
  output bpa_pkg::dp_status_t          status_o,
  output logic [PAGE_BITS-1:0]         res_page_o,
  output bpa_pkg::status_e             res_status_o
);
  import bpa_pkg::*;

  localparam int unsigned AW = PAGE_BITS;
  localparam int unsigned NP = 1 << AW;
  localparam int unsigned WW = ((AW > 15) ? AW : 15) + 2;
  localparam int unsigned KW = ORDER_LIMIT + 1;
  localparam int unsigned HW = $clog2(ORDER_LIMIT + 1);
  localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(ORDER_LIMIT);

  typedef struct packed {
    logic             usable;
    logic             alloc;
    logic             head;
    logic [ORD_W-1:0] order;
    logic [AW-1:0]    prev;
    logic [AW-1:0]    next;
  } pword_t;

  pword_t mem [NP];
  pword_t rd_q;
  pword_t wd;
  logic          we, re;
  logic [AW-1:0] wa, ra;

  logic [AW-1:0]    a_q, a_d;
  cmd_e             cmd_q, cmd_d;
  logic [AW-1:0]    pg_q, pg_d;
  logic [ORD_W-1:0] ordin_q, ordin_d;
  logic             usable_q, usable_d, alloc_q, alloc_d;
  logic [WW-1:0]    i_q, i_d, j_q, j_d;
  logic [ORD_W-1:0] ord_q, ord_d, o_q, o_d;
  logic [KW-1:0]    k_q, k_d;
  logic [AW-1:0]    x_q, x_d, p_q, p_d, n_q, n_d, old_q, old_d, ma_q, ma_d;
  logic [AW-1:0]    head_q [ORDER_LIMIT+1];
  logic [AW-1:0]    head_d [ORDER_LIMIT+1];
  logic [AW-1:0]    res_q, res_d;
  status_e          st_q, st_d;
  logic [LOW_W-1:0]  lo_q;
  logic [HIGH_W-1:0] hi_q;

  logic [WW-1:0] lo_eff, hi_eff, bs, sz_ord, bud;
  logic [AW-1:0] head_o, kaddr, split_x;
  logic [HW-1:0] o_idx;

  // Region bounds and block geometry.
  always_comb begin
    lo_eff  = (lo_q == '0) ? WW'(1) : WW'(lo_q);
    hi_eff  = (WW'(hi_q) > WW'(NP)) ? WW'(NP) : WW'(hi_q);
    bs      = WW'(1) << ({1'b0, ord_q} + 5'd1);
    sz_ord  = WW'(1) << ord_q;
    bud     = WW'(pg_q) ^ sz_ord;
    o_idx   = o_q[HW-1:0];
    head_o  = head_q[o_idx];
    kaddr   = AW'(WW'(pg_q) + WW'(k_q));
    split_x = pg_q + (AW'(1) << (o_q - ORD_W'(1)));
  end

  // Conditions for the controller.
  always_comb begin
    status_o.cmd       = cmd_q;
    status_o.ord_bad   = ordin_q > MAX_ORD;
    status_o.pg_zero   = pg_q == '0;
    status_o.a_last    = a_q == AW'(NP - 1);
    status_o.free_ok   = rd_q.usable && !rd_q.alloc;
    status_o.i_lt_hi   = i_q < hi_eff;
    status_o.grow_ok   = (ord_q < MAX_ORD) && ((i_q & (bs - WW'(1))) == '0)
                         && (i_q + bs <= hi_eff);
    status_o.j_last    = j_q == i_q + bs - WW'(1);
    status_o.tail_more = j_q < i_q + sz_ord;
    status_o.old_nz    = old_q != '0;
    status_o.p_nz      = p_q != '0;
    status_o.n_nz      = n_q != '0;
    status_o.head_zero = head_o == '0;
    status_o.o_max     = o_q == MAX_ORD;
    status_o.o_gt_ord  = o_q > ordin_q;
    status_o.k_more    = k_q < (KW'(1) << ordin_q);
    status_o.merge_ok  = (ord_q < MAX_ORD) && (bud >= lo_eff) && (bud + sz_ord <= hi_eff);
    status_o.bud_ok    = !rd_q.alloc && rd_q.head && (rd_q.order == ord_q);
  end

  // Micro-operation decode: register updates and page table access.
  always_comb begin
    a_d = a_q; cmd_d = cmd_q; pg_d = pg_q; ordin_d = ordin_q;
    usable_d = usable_q; alloc_d = alloc_q; i_d = i_q; j_d = j_q;
    ord_d = ord_q; o_d = o_q; k_d = k_q; x_d = x_q; p_d = p_q; n_d = n_q;
    old_d = old_q; ma_d = ma_q; res_d = res_q; st_d = st_q;
    head_d = head_q;
    we = 1'b0; re = 1'b0; wa = ma_q; ra = '0; wd = rd_q;
    case (op_i)
      OP_LOAD: begin
        cmd_d = in_cmd_i; pg_d = in_page_i; ordin_d = in_order_i;
        usable_d = in_usable_i; alloc_d = in_alloc_i;
        a_d = '0; res_d = '0; st_d = ST_OK;
      end
      OP_CLR: begin
        we = 1'b1; wa = a_q; wd = '0; a_d = a_q + AW'(1);
      end
      OP_RD_A:  begin re = 1'b1; ra = a_q; end
      OP_WR_LNK0: begin
        we = 1'b1; wd.prev = '0; wd.next = '0; a_d = a_q + AW'(1);
      end
      OP_RD_PG: begin re = 1'b1; ra = pg_q; end
      OP_WR_MARK: begin
        we = 1'b1; wd.usable = usable_q; wd.alloc = alloc_q;
      end
      OP_B_INIT: begin
        for (int h = 0; h <= ORDER_LIMIT; h++) head_d[h] = '0;
        i_d = lo_eff;
      end
      OP_RD_I:    begin re = 1'b1; ra = i_q[AW-1:0]; end
      OP_I_INC:   i_d = i_q + WW'(1);
      OP_G_INIT:  ord_d = '0;
      OP_J_INIT:  j_d = i_q + sz_ord;
      OP_RD_J:    begin re = 1'b1; ra = j_q[AW-1:0]; end
      OP_J_INC:   j_d = j_q + WW'(1);
      OP_ORD_INC: ord_d = ord_q + ORD_W'(1);
      OP_T_INIT: begin
        j_d = i_q + WW'(1); x_d = i_q[AW-1:0]; o_d = ord_q;
      end
      OP_WR_TAIL: begin
        we = 1'b1; wd.order = '0; wd.head = 1'b0; j_d = j_q + WW'(1);
      end
      OP_I_ADV:   i_d = i_q + sz_ord;
      OP_P_RD:    begin re = 1'b1; ra = x_q; old_d = head_o; end
      OP_P_WR: begin
        we = 1'b1; wd.order = o_q; wd.head = 1'b1; wd.prev = '0; wd.next = old_q;
        head_d[o_idx] = x_q;
      end
      OP_P_RDO:   begin re = 1'b1; ra = old_q; end
      OP_P_WRO:   begin we = 1'b1; wd.prev = x_q; end
      OP_U_RD:    begin re = 1'b1; ra = x_q; end
      OP_U_CAP: begin
        p_d = rd_q.prev; n_d = rd_q.next;
        if (rd_q.prev == '0) head_d[o_idx] = rd_q.next;
      end
      OP_U_RDP:   begin re = 1'b1; ra = p_q; end
      OP_U_WRP:   begin we = 1'b1; wd.next = n_q; end
      OP_U_RDN:   begin re = 1'b1; ra = n_q; end
      OP_U_WRN:   begin we = 1'b1; wd.prev = p_q; end
      OP_U_RDX:   begin re = 1'b1; ra = x_q; end
      OP_U_WRX:   begin we = 1'b1; wd.prev = '0; wd.next = '0; end
      OP_A_INIT:  o_d = ordin_q;
      OP_A_NEXT:  o_d = o_q + ORD_W'(1);
      OP_A_FAIL:  st_d = ST_NO_MEM;
      OP_A_TAKE:  begin pg_d = head_o; x_d = head_o; end
      OP_A_SPLIT: begin o_d = o_q - ORD_W'(1); x_d = split_x; end
      OP_K0:      begin k_d = '0; ord_d = ordin_q; end
      OP_RD_K:    begin re = 1'b1; ra = kaddr; end
      OP_A_WRK: begin
        we = 1'b1; wd.alloc = 1'b1;
        if (k_q == '0) begin
          wd.order = ordin_q; wd.head = 1'b1;
        end else begin
          wd.head = 1'b0;
        end
        k_d = k_q + KW'(1);
      end
      OP_A_RES:   res_d = pg_q;
      OP_F_WRK:   begin we = 1'b1; wd.alloc = 1'b0; k_d = k_q + KW'(1); end
      OP_BAD:     st_d = ST_BAD_ORDER;
      OP_F_RDB: begin
        re = 1'b1; ra = bud[AW-1:0]; x_d = bud[AW-1:0]; o_d = ord_q;
      end
      OP_F_MRG: begin
        if (bud < WW'(pg_q)) pg_d = bud[AW-1:0];
        ord_d = ord_q + ORD_W'(1);
      end
      OP_F_FIN:   begin x_d = pg_q; o_d = ord_q; end
      default: ;
    endcase
    if (re) ma_d = ra;
  end

  // Page table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      lo_q <= LOW_RESET;
      hi_q <= HIGH_RESET;
      for (int h = 0; h <= ORDER_LIMIT; h++) head_q[h] <= '0;
    end else begin
      a_q    <= a_d;
      head_q <= head_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOW:  lo_q <= cfg_data_i[LOW_W-1:0];
          REG_HIGH: hi_q <= cfg_data_i[HIGH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; pg_q <= pg_d; ordin_q <= ordin_d;
    usable_q <= usable_d; alloc_q <= alloc_d; i_q <= i_d; j_q <= j_d;
    ord_q <= ord_d; o_q <= o_d; k_q <= k_d; x_q <= x_d; p_q <= p_d; n_q <= n_d;
    old_q <= old_d; ma_q <= ma_d; res_q <= res_d; st_q <= st_d;
  end

  assign res_page_o   = res_q;
  assign res_status_o = st_q;

endmodule
`default_nettype wire

// ===== src/bpa_ctrl.sv =====
`default_nettype none
module bpa_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  wire                 m_ready_i,
  input  bpa_pkg::dp_status_t status_i,
  output bpa_pkg::dp_op_e     op_o
);
  import bpa_pkg::*;

  ctl_state_e state_q, state_d, ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_DONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Sequencer: next state and micro-operation.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    op_o      = OP_IDLE;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        op_o = OP_CLR;
        if (status_i.a_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          op_o = OP_LOAD; state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.cmd)
          CMD_MARK:  begin op_o = OP_RD_PG; state_d = S_MARK_WR; end
          CMD_BUILD: begin op_o = OP_RD_A;  state_d = S_BL_WR;   end
          CMD_ALLOC: begin
            if (status_i.ord_bad) begin
              op_o = OP_BAD; state_d = S_DONE;
            end else begin
              op_o = OP_A_INIT; state_d = S_A_FIND;
            end
          end
          CMD_FREE: begin
            if (status_i.ord_bad) begin
              op_o = OP_BAD; state_d = S_DONE;
            end else if (status_i.pg_zero) begin
              state_d = S_DONE;
            end else begin
              op_o = OP_K0; state_d = S_F_KRD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MARK_WR: begin op_o = OP_WR_MARK; state_d = S_DONE; end
      // Build: clear every link, then scan the region.
      S_BL_WR: begin
        op_o = OP_WR_LNK0;
        state_d = status_i.a_last ? S_B_INIT : S_BL_RD;
      end
      S_BL_RD:  begin op_o = OP_RD_A; state_d = S_BL_WR; end
      S_B_INIT: begin op_o = OP_B_INIT; state_d = S_B_TEST; end
      S_B_TEST: begin
        if (status_i.i_lt_hi) begin
          op_o = OP_RD_I; state_d = S_B_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_B_CHK: begin
        if (!status_i.free_ok) begin
          op_o = OP_I_INC; state_d = S_B_TEST;
        end else begin
          op_o = OP_G_INIT; state_d = S_B_GROW;
        end
      end
      S_B_GROW: begin
        if (status_i.grow_ok) begin
          op_o = OP_J_INIT; state_d = S_B_JRD;
        end else begin
          op_o = OP_T_INIT; state_d = S_B_TCHK;
        end
      end
      S_B_JRD: begin op_o = OP_RD_J; state_d = S_B_JCHK; end
      S_B_JCHK: begin
        if (!status_i.free_ok) begin
          op_o = OP_T_INIT; state_d = S_B_TCHK;
        end else if (status_i.j_last) begin
          op_o = OP_ORD_INC; state_d = S_B_GROW;
        end else begin
          op_o = OP_J_INC; state_d = S_B_JRD;
        end
      end
      S_B_TCHK: begin
        if (status_i.tail_more) begin
          op_o = OP_RD_J; state_d = S_B_TWR;
        end else begin
          ret_d = S_B_ADV; state_d = S_P_RD;
        end
      end
      S_B_TWR: begin op_o = OP_WR_TAIL; state_d = S_B_TCHK; end
      S_B_ADV: begin op_o = OP_I_ADV; state_d = S_B_TEST; end
      // Push a block onto the head of its list.
      S_P_RD: begin op_o = OP_P_RD; state_d = S_P_WR; end
      S_P_WR: begin
        op_o = OP_P_WR;
        state_d = status_i.old_nz ? S_P_RDO : ret_q;
      end
      S_P_RDO: begin op_o = OP_P_RDO; state_d = S_P_WRO; end
      S_P_WRO: begin op_o = OP_P_WRO; state_d = ret_q; end
      // Unlink a block from its list.
      S_U_RD:  begin op_o = OP_U_RD; state_d = S_U_CAP; end
      S_U_CAP: begin op_o = OP_U_CAP; state_d = S_U_CHKP; end
      S_U_CHKP: begin
        if (status_i.p_nz) begin
          op_o = OP_U_RDP; state_d = S_U_WRP;
        end else begin
          state_d = S_U_CHKN;
        end
      end
      S_U_WRP: begin op_o = OP_U_WRP; state_d = S_U_CHKN; end
      S_U_CHKN: begin
        if (status_i.n_nz) begin
          op_o = OP_U_RDN; state_d = S_U_WRN;
        end else begin
          op_o = OP_U_RDX; state_d = S_U_WRX;
        end
      end
      S_U_WRN: begin op_o = OP_U_WRN; state_d = S_U_RDX; end
      S_U_RDX: begin op_o = OP_U_RDX; state_d = S_U_WRX; end
      S_U_WRX: begin op_o = OP_U_WRX; state_d = ret_q; end
      // Allocate: find a list, take its head, split down.
      S_A_FIND: begin
        if (!status_i.head_zero) begin
          op_o = OP_A_TAKE; ret_d = S_A_SPLIT; state_d = S_U_RD;
        end else if (status_i.o_max) begin
          op_o = OP_A_FAIL; state_d = S_DONE;
        end else begin
          op_o = OP_A_NEXT;
        end
      end
      S_A_SPLIT: begin
        if (status_i.o_gt_ord) begin
          op_o = OP_A_SPLIT; ret_d = S_A_SPLIT; state_d = S_P_RD;
        end else begin
          op_o = OP_K0; state_d = S_A_KRD;
        end
      end
      S_A_KRD: begin
        if (status_i.k_more) begin
          op_o = OP_RD_K; state_d = S_A_KWR;
        end else begin
          op_o = OP_A_RES; state_d = S_DONE;
        end
      end
      S_A_KWR: begin op_o = OP_A_WRK; state_d = S_A_KRD; end
      // Free: clear marks, merge with buddies, push.
      S_F_KRD: begin
        if (status_i.k_more) begin
          op_o = OP_RD_K; state_d = S_F_KWR;
        end else begin
          state_d = S_F_MRG;
        end
      end
      S_F_KWR: begin op_o = OP_F_WRK; state_d = S_F_KRD; end
      S_F_MRG: begin
        if (status_i.merge_ok) begin
          op_o = OP_F_RDB; state_d = S_F_BCHK;
        end else begin
          op_o = OP_F_FIN; ret_d = S_DONE; state_d = S_P_RD;
        end
      end
      S_F_BCHK: begin
        if (status_i.bud_ok) begin
          ret_d = S_F_UP; state_d = S_U_RD;
        end else begin
          op_o = OP_F_FIN; ret_d = S_DONE; state_d = S_P_RD;
        end
      end
      S_F_UP: begin op_o = OP_F_MRG; state_d = S_F_MRG; end
      S_DONE: begin
        m_valid_o = 1'b1;
        if (m_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Input and output sides never both active.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_ready_o |-> !m_valid_o)
    else $error("input ready while a result is pending");

  // An accepted word always starts a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_DISPATCH))
    else $error("accepted word did not dispatch");

  // A delivered result returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_ready_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");

  // No input is taken during the table clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_ready_o)
    else $error("input accepted during table clear");

endmodule
`default_nettype wire

// ===== src/buddy_page_allocator.sv =====
`default_nettype none
// Mark reads the page entry and writes its marks before the result; allocate and free also
//   walk every page of the block, each order split and each order merged.
// Build: clears every link, then scans the region page by page, marks the tail pages of
//   each block formed and pushes it onto its list.
// Throughput: one command at a time; the next word is accepted after the result is taken.
// Reset: the page table is cleared with s_axis_tready low.
module buddy_page_allocator #(
  parameter int unsigned PAGE_BITS   = bpa_pkg::PAGE_BITS_DEF,
  parameter int unsigned ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       s_axis_tvalid,
  output logic                                      s_axis_tready,
  // page, order, usable, allocated (zero padded)
  input  wire [((PAGE_BITS+6+7)/8)*8-1:0]           s_axis_tdata,
  // cmd
  input  wire [1:0]                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire                                       m_axis_tready,
  // result_page, status (zero padded)
  output logic [((PAGE_BITS+2+7)/8)*8-1:0]          m_axis_tdata,
  input  wire                                       cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire                                       cfg_index_i,
  input  wire [bpa_pkg::CFG_W-1:0]                  cfg_data_i
);
  import bpa_pkg::*;

  localparam int unsigned AW    = PAGE_BITS;
  localparam int unsigned OUT_W = ((AW + 2 + 7) / 8) * 8;

  dp_op_e        op;
  dp_status_t    dp_status;
  logic [AW-1:0] res_page;
  status_e       res_status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (dp_status),
    .op_o      (op)
  );

  bpa_datapath #(
    .PAGE_BITS   (PAGE_BITS),
    .ORDER_LIMIT (ORDER_LIMIT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_page_i    (s_axis_tdata[AW-1:0]),
    .in_order_i   (s_axis_tdata[AW+ORD_W-1:AW]),
    .in_usable_i  (s_axis_tdata[AW+4]),
    .in_alloc_i   (s_axis_tdata[AW+5]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (reg_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .status_o     (dp_status),
    .res_page_o   (res_page),
    .res_status_o (res_status)
  );

  // Result word.
  assign m_axis_tdata = OUT_W'({res_status, res_page});

endmodule
`default_nettype wire

// ===== sim/bpa_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Watches the command, result and register channels of the page allocator, keeps its own
// copy of the page table and free lists, and compares every result word with the prediction.
module bpa_checker (
  input  wire                      clk_i,
  input  wire                      s_valid_i,
  input  wire                      s_ready_i,
  input  wire [23:0]               s_data_i,
  input  wire [1:0]                s_user_i,
  input  wire                      m_valid_i,
  input  wire                      m_ready_i,
  input  wire [15:0]               m_data_i,
  input  wire                      cfg_valid_i,
  input  wire                      cfg_ready_i,
  input  wire                      cfg_index_i,
  input  wire [bpa_pkg::CFG_W-1:0] cfg_data_i,
  output int                       fails_o,
  output int                       pending_o
);
  import bpa_pkg::*;

  localparam int unsigned NPG     = 1 << PAGE_BITS_DEF;
  localparam int unsigned PMASK   = NPG - 1;
  localparam int unsigned MAX_ORD = ORDER_LIMIT_DEF;

  typedef struct {
    logic [11:0] page;
    status_e     st;
  } outcome_t;

  // Shadow page table and free lists.
  bit          usable_q [NPG];
  bit          taken_q  [NPG];
  bit          head_q   [NPG];
  logic [3:0]  ord_q    [NPG];
  logic [11:0] prv_q    [NPG];
  logic [11:0] nxt_q    [NPG];
  logic [11:0] lhead_q  [MAX_ORD+1];
  logic [LOW_W-1:0]  low_q;
  logic [HIGH_W-1:0] high_q;

  outcome_t outcome_q[$];

  function automatic int unsigned eff_low();
    return (low_q == 0) ? 1 : int'(low_q);
  endfunction

  function automatic int unsigned eff_high();
    return (high_q > NPG) ? NPG : int'(high_q);
  endfunction

  function automatic bit page_free(input int unsigned pg);
    return usable_q[pg & PMASK] && !taken_q[pg & PMASK];
  endfunction

  function automatic void unlink_blk(input int unsigned pg, input int unsigned o);
    int unsigned p, n;
    p = prv_q[pg & PMASK];
    n = nxt_q[pg & PMASK];
    if (p != 0) nxt_q[p] = n;
    else lhead_q[o] = n;
    if (n != 0) prv_q[n] = p;
    prv_q[pg & PMASK] = 0;
    nxt_q[pg & PMASK] = 0;
  endfunction

  function automatic void push_blk(input int unsigned pg, input int unsigned o);
    int unsigned old;
    old = lhead_q[o];
    pg  = pg & PMASK;
    prv_q[pg] = 0;
    nxt_q[pg] = old;
    if (old != 0) prv_q[old] = pg;
    lhead_q[o] = pg;
  endfunction

  // Group free usable pages of the region into the largest aligned blocks.
  task automatic build_free_lists();
    int unsigned lo, hi, i, j, o, bs, sz;
    bit ok;
    lo = eff_low();
    hi = eff_high();
    for (i = 0; i < NPG; i++) begin
      prv_q[i] = 0;
      nxt_q[i] = 0;
    end
    for (i = 0; i <= MAX_ORD; i++) lhead_q[i] = 0;
    i = lo;
    while (i < hi) begin
      if (!page_free(i)) begin
        i++;
        continue;
      end
      o = 0;
      while (o < MAX_ORD) begin
        bs = 1 << (o + 1);
        ok = 1;
        if ((i & (bs - 1)) != 0 || i + bs > hi) break;
        for (j = i + (1 << o); j < i + bs; j++) begin
          if (!page_free(j)) begin
            ok = 0;
            break;
          end
        end
        if (!ok) break;
        o++;
      end
      sz = 1 << o;
      ord_q[i]  = o;
      head_q[i] = 1;
      for (j = 1; j < sz; j++) begin
        ord_q[(i + j) & PMASK]  = 0;
        head_q[(i + j) & PMASK] = 0;
      end
      push_blk(i, o);
      i += sz;
    end
  endtask

  // Take the first block of the smallest sufficient order and split it down.
  function automatic int unsigned take_block(input int unsigned o);
    int unsigned cur, pg, bud, k;
    cur = o;
    while (cur <= MAX_ORD && lhead_q[cur] == 0) cur++;
    if (cur > MAX_ORD) return 0;
    pg = lhead_q[cur];
    unlink_blk(pg, cur);
    while (cur > o) begin
      cur--;
      bud = (pg + (1 << cur)) & PMASK;
      ord_q[bud]  = cur;
      head_q[bud] = 1;
      push_blk(bud, cur);
    end
    ord_q[pg]  = o;
    head_q[pg] = 1;
    for (k = 0; k < (1 << o); k++) taken_q[(pg + k) & PMASK] = 1;
    for (k = 1; k < (1 << o); k++) head_q[(pg + k) & PMASK] = 0;
    return pg;
  endfunction

  // Release a block and merge it with free head buddies inside the region.
  task automatic release_block(input int unsigned pg, input int unsigned o);
    int unsigned k, lo, hi, bud;
    lo = eff_low();
    hi = eff_high();
    for (k = 0; k < (1 << o); k++) taken_q[(pg + k) & PMASK] = 0;
    while (o < MAX_ORD) begin
      bud = pg ^ (1 << o);
      if (bud < lo || bud + (1 << o) > hi) break;
      if (taken_q[bud] || !head_q[bud] || ord_q[bud] != o) break;
      unlink_blk(bud, o);
      if (bud < pg) pg = bud;
      o++;
    end
    pg = pg & PMASK;
    ord_q[pg]  = o;
    head_q[pg] = 1;
    push_blk(pg, o);
  endtask

  initial begin
    for (int i = 0; i < NPG; i++) begin
      usable_q[i] = 0;
      taken_q[i]  = 0;
      head_q[i]   = 0;
      ord_q[i]    = 0;
      prv_q[i]    = 0;
      nxt_q[i]    = 0;
    end
    for (int i = 0; i <= MAX_ORD; i++) lhead_q[i] = 0;
    low_q     = LOW_RESET;
    high_q    = HIGH_RESET;
    fails_o   = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    cmd_e        cmd;
    int unsigned pg, o;
    outcome_t    want, got;

    // Register writes.
    if (cfg_valid_i && cfg_ready_i) begin
      if (reg_e'(cfg_index_i) == REG_LOW) low_q = cfg_data_i[LOW_W-1:0];
      else high_q = cfg_data_i[HIGH_W-1:0];
    end

    // Each accepted command word yields exactly one expected result.
    if (s_valid_i && s_ready_i) begin
      cmd = cmd_e'(s_user_i);
      pg  = s_data_i[11:0];
      o   = s_data_i[15:12];
      want.page = 0;
      want.st   = ST_OK;
      case (cmd)
        CMD_MARK: begin
          usable_q[pg] = s_data_i[16];
          taken_q[pg]  = s_data_i[17];
        end
        CMD_BUILD: build_free_lists();
        CMD_ALLOC: begin
          if (o > MAX_ORD) want.st = ST_BAD_ORDER;
          else begin
            want.page = take_block(o);
            if (want.page == 0) want.st = ST_NO_MEM;
          end
        end
        default: begin
          if (o > MAX_ORD) want.st = ST_BAD_ORDER;
          else if (pg != 0) release_block(pg, o);
        end
      endcase
      outcome_q.push_back(want);
    end

    // Compare result words in order.
    if (m_valid_i && m_ready_i) begin
      got.page = m_data_i[11:0];
      got.st   = status_e'(m_data_i[13:12]);
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result word page %0d status %0d", $time, got.page, got.st);
        fails_o++;
      end else begin
        want = outcome_q.pop_front();
        if (got.page !== want.page) begin
          $display("%0t: result_page expected %0d actual %0d", $time, want.page, got.page);
          fails_o++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          fails_o++;
        end
      end
    end
    pending_o = outcome_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bpa_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  int                fails;
  int                pending;

  typedef struct {
    int unsigned page;
    int unsigned ord;
  } block_t;

  block_t      live_q[$];
  cmd_e        cmd_log_q[$];
  int unsigned alloc_ord_q[$];
  int          burst_left;
  int          stall_mode;
  int          stall_cnt;

  buddy_page_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  bpa_checker chk (
    .clk_i(clk_i),
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fails_o(fails), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver stalls on its own pattern, picked at random from four modes.
  initial begin
    m_axis_tready = 1'b0;
    stall_mode    = 0;
    stall_cnt     = 0;
  end
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cnt % 8 >= 5);
    endcase
  end

  // Track allocated blocks so that most frees return real blocks.
  always @(posedge clk_i) begin
    cmd_e        c;
    int unsigned o;
    block_t      b;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_log_q.push_back(cmd_e'(s_axis_tuser));
      if (cmd_e'(s_axis_tuser) == CMD_ALLOC) alloc_ord_q.push_back(s_axis_tdata[15:12]);
    end
    if (m_axis_tvalid && m_axis_tready && cmd_log_q.size() > 0) begin
      c = cmd_log_q.pop_front();
      if (c == CMD_ALLOC) begin
        o = alloc_ord_q.pop_front();
        if (m_axis_tdata[13:12] == ST_OK) begin
          b.page = m_axis_tdata[11:0];
          b.ord  = o;
          live_q.push_back(b);
        end
      end
    end
  end

  // Send one command word; bursts of random length with random gaps between them.
  task automatic send_word(input cmd_e cmd, input int unsigned pg, input int unsigned o,
                           input bit u, input bit a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, a, u, o[3:0], pg[11:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every expected result has arrived and the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic free_some();
    int k;
    block_t b;
    if (live_q.size() == 0) begin
      send_word(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 3), 0, 0);
    end else begin
      k = $urandom_range(0, live_q.size() - 1);
      b = live_q[k];
      live_q.delete(k);
      send_word(CMD_FREE, b.page, b.ord, $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  int unsigned lows[7]  = '{13'h1000, 4032, 100, 1, 2048, 4095, 1537};
  int unsigned highs[7] = '{64, 8191, 50, 4096, 2248, 4096, 1700};

  initial begin
    int unsigned base, r;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_MARK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_LOW;
    cfg_data_i    = '0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset region.
    send_word(CMD_ALLOC, 0, 0, 0, 0);       // empty lists: out of memory
    send_word(CMD_ALLOC, 0, 11, 0, 0);      // order above maximum
    send_word(CMD_ALLOC, 4095, 15, 1, 1);
    send_word(CMD_FREE, 5, 15, 0, 0);
    send_word(CMD_FREE, 0, 0, 0, 0);        // free of page zero is ignored
    send_word(CMD_MARK, 0, 0, 1, 1);
    send_word(CMD_MARK, 4095, 15, 1, 1);
    for (int p = 1024; p < 1032; p++) send_word(CMD_MARK, p, 0, 1, 0);
    send_word(CMD_MARK, 1032, 0, 1, 1);
    send_word(CMD_MARK, 1033, 0, 0, 0);
    send_word(CMD_BUILD, 0, 0, 0, 0);
    send_word(CMD_ALLOC, 0, 3, 0, 0);
    send_word(CMD_ALLOC, 0, 1, 0, 0);
    send_word(CMD_FREE, 1024, 3, 0, 0);
    send_word(CMD_ALLOC, 0, 0, 0, 0);       // splits down to a single page
    send_word(CMD_ALLOC, 0, 10, 0, 0);
    send_word(CMD_FREE, 1024, 0, 0, 0);     // merges back up
    send_word(CMD_FREE, 1025, 1, 0, 0);     // unaligned free
    send_word(CMD_FREE, 2000, 10, 0, 0);    // foreign free of a large block
    drain();

    // Random phases, one per region setting.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_LOW, lows[ph]);
      write_reg(REG_HIGH, highs[ph]);
      live_q.delete();
      base = lows[ph] & 12'hFFF;
      if (base == 0) base = 1;
      if (base > 4096 - 48) base = 4096 - 48;
      if (ph == 2) base = 48;
      for (int p = 0; p < 48; p++) begin
        send_word(CMD_MARK, base + p, $urandom_range(0, 15), ($urandom_range(0, 9) != 0),
                  ($urandom_range(0, 7) == 0));
      end
      send_word(CMD_BUILD, $urandom_range(0, 4095), $urandom_range(0, 15), 0, 0);
      for (int n = 0; n < 30; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_word(CMD_ALLOC, $urandom_range(0, 4095),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        end else if (r < 85) begin
          free_some();
        end else if (r < 93) begin
          send_word(CMD_FREE, $urandom_range(0, 4095),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5),
                    0, 0);
        end else if (r < 98) begin
          send_word(CMD_MARK, $urandom_range(0, 4095), $urandom_range(0, 15),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          live_q.delete();
          send_word(CMD_BUILD, 0, 0, 0, 0);
        end
      end
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("buddy_page_allocator: match");
    end else begin
      $display("buddy_page_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("buddy_page_allocator: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/bpa_pkg.sv
src/bpa_datapath.sv
src/bpa_ctrl.sv
src/buddy_page_allocator.sv
sim/bpa_checker.sv
sim/testbench.sv
